// ===== rtl/skaf_pkg.sv =====
package skaf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GAIN_BITS = 16;
   localparam logic [16:0] GAIN_ONE = 17'h10000;
   localparam logic [31:0] COV_MAX = 32'h7FFF_FFFF;

   localparam logic [16:0] PERIOD_RESET = 17'd131;
   localparam logic [24:0] QNOISE_RESET = 25'd196608;
   localparam logic [27:0] RNOISE_RESET = 28'd98304000;

   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_QNOISE = 2'd1;
   localparam logic [1:0] CSR_RNOISE = 2'd2;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;  // latch inputs, start rate*period
   localparam logic [3:0] OP_PRIOR   = 4'd2;  // form prior angle
   localparam logic [3:0] OP_SQ1     = 4'd3;  // P*P
   localparam logic [3:0] OP_SQ2     = 4'd4;  // q*q, sum
   localparam logic [3:0] OP_SQRT_PP = 4'd5;  // start root for Pp
   localparam logic [3:0] OP_PP2     = 4'd6;  // Pp*Pp
   localparam logic [3:0] OP_R2      = 4'd7;  // r*r, denominator
   localparam logic [3:0] OP_DIV     = 4'd8;  // start ratio divider
   localparam logic [3:0] OP_SQRT_K  = 4'd9;  // start root for gain
   localparam logic [3:0] OP_CORR    = 4'd10; // latch gain from root
   localparam logic [3:0] OP_ANGLE   = 4'd11; // gain*(meas-prior), (1-K)*hi
   localparam logic [3:0] OP_SCALE   = 4'd12; // new angle, (1-K)*lo, scaled sum
   localparam logic [3:0] OP_SQRT_P  = 4'd13; // start root for new P
   localparam logic [3:0] OP_COMMIT  = 4'd14; // write state as the word is taken

   typedef struct packed {
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic den_zero;
   } dp_status_type;

endpackage

// ===== rtl/skaf_sqrt.sv =====
module skaf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        busy,
   output logic [31:0] root
);

   // Restoring root, one result bit per cycle.
   logic [63:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [63:0] src_ff, src_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [65:0] trial;
   logic [65:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      src_in  = src_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, src_ff[63:62]};
      trial   = shifted - {32'd0, res_ff, 2'b01};
      if (start) begin
         rem_in  = '0;
         res_in  = '0;
         src_in  = operand;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in = {src_ff[61:0], 2'b00};
         if (!trial[65]) begin
            rem_in = trial[63:0];
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            res_in = {res_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      src_ff <= src_in;
   end

   assign busy = busy_ff;
   assign root = res_ff;

endmodule

// ===== rtl/skaf_div.sv =====
module skaf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic [32:0] quot
);

   // floor(num * 2^32 / den) for num <= den, one quotient bit per cycle.
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [32:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        ge;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      ge      = rem_ff >= {1'b0, den_ff};
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[31:0], ge};
         if (ge) rem_in = rem_ff - {1'b0, den_ff};
         if (cnt_ff != 6'd1) rem_in = {rem_in[63:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/skaf_datapath.sv =====
module skaf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  skaf_pkg::dp_cmd_type    cmd,
   output skaf_pkg::dp_status_type status,
   input  logic [31:0]             accel_angle,
   input  logic [31:0]             gyro_rate,
   input  logic [16:0]             period,
   input  logic [24:0]             qnoise,
   input  logic [27:0]             rnoise,
   output logic [31:0]             angle_out,
   output logic [16:0]             gain_out
);

   logic signed [31:0] meas_ff;
   logic signed [49:0] prod_ff;          // rate * period
   logic signed [31:0] prior_ff;
   logic signed [31:0] angle_ff;         // posterior angle
   logic [31:0]        cov_ff;           // posterior covariance
   logic [63:0]        acc_ff;           // shared wide scratch
   logic [63:0]        pp2_ff;
   logic [63:0]        den_ff;
   logic [16:0]        gain_ff;
   logic signed [50:0] corr_ff;
   logic [63:0]        hiprod_ff;
   logic [63:0]        sqrt_op;
   logic               sqrt_start, div_start;
   logic               sqrt_busy, div_busy;
   logic [31:0]        root;
   logic [32:0]        quot;

   logic [49:0]        mag;
   logic [34:0]        rmag;
   logic signed [34:0] delta;
   logic signed [34:0] pdiff;
   logic signed [32:0] mdiff;
   logic [50:0]        cmag;
   logic [35:0]        crnd;
   logic signed [35:0] csgn;
   logic signed [35:0] asum;
   logic [16:0]        omk;
   logic [31:0]        pp_sat;

   always_comb begin
      mag   = prod_ff[49] ? 50'(-prod_ff) : 50'(prod_ff);
      rmag  = 35'((mag + 50'(1 << (skaf_pkg::FRAC_BITS - 1))) >> skaf_pkg::FRAC_BITS);
      delta = prod_ff[49] ? -$signed(rmag) : $signed(rmag);
      pdiff = 35'(angle_ff) - delta;
      mdiff = 33'(meas_ff) - 33'(prior_ff);
      cmag  = corr_ff[50] ? 51'(-corr_ff) : 51'(corr_ff);
      crnd  = 36'((cmag + 51'(1 << (skaf_pkg::GAIN_BITS - 1))) >> skaf_pkg::GAIN_BITS);
      csgn  = corr_ff[50] ? -$signed(crnd) : $signed(crnd);
      asum  = 36'(prior_ff) + csgn;
      omk   = skaf_pkg::GAIN_ONE - gain_ff;
      pp_sat = (root > skaf_pkg::COV_MAX) ? skaf_pkg::COV_MAX : root;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      sqrt_op    = acc_ff;
      case (cmd.op) inside
         skaf_pkg::OP_SQRT_PP, skaf_pkg::OP_SQRT_P: sqrt_start = 1'b1;
         skaf_pkg::OP_SQRT_K: begin
            sqrt_start = 1'b1;
            sqrt_op    = {31'd0, quot};
         end
         skaf_pkg::OP_DIV: div_start = 1'b1;
         default: ;
      endcase
   end

   skaf_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .operand(sqrt_op),
      .busy(sqrt_busy), .root(root)
   );

   skaf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(pp2_ff), .den(den_ff),
      .busy(div_busy), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         cov_ff   <= '0;
      end else if (cmd.op == skaf_pkg::OP_COMMIT) begin
         angle_ff <= angle_out;
         cov_ff   <= pp_sat;
      end
      case (cmd.op)
         skaf_pkg::OP_LOAD: begin
            meas_ff <= accel_angle;
            prod_ff <= 50'($signed(gyro_rate)) * 50'($signed({1'b0, period}));
         end
         skaf_pkg::OP_PRIOR: begin
            if (pdiff > 35'sd2147483647) prior_ff <= 32'h7FFF_FFFF;
            else if (pdiff < -35'sd2147483648) prior_ff <= 32'h8000_0000;
            else prior_ff <= pdiff[31:0];
         end
         skaf_pkg::OP_SQ1: acc_ff <= 64'(cov_ff) * 64'(cov_ff);
         skaf_pkg::OP_SQ2: acc_ff <= acc_ff + 64'(qnoise) * 64'(qnoise);
         skaf_pkg::OP_PP2: pp2_ff <= 64'(pp_sat) * 64'(pp_sat);
         skaf_pkg::OP_R2: den_ff <= pp2_ff + 64'(rnoise) * 64'(rnoise);
         skaf_pkg::OP_CORR: begin
            if (den_ff == 64'd0) gain_ff <= skaf_pkg::GAIN_ONE;
            else if (root > 32'(skaf_pkg::GAIN_ONE)) gain_ff <= skaf_pkg::GAIN_ONE;
            else gain_ff <= root[16:0];
         end
         skaf_pkg::OP_ANGLE: begin
            corr_ff   <= 51'(mdiff) * 51'($signed({1'b0, gain_ff}));
            hiprod_ff <= 64'(omk) * 64'(pp2_ff[63:16]);
         end
         skaf_pkg::OP_SCALE: begin
            if (asum > 36'sd2147483647) angle_out <= 32'h7FFF_FFFF;
            else if (asum < -36'sd2147483648) angle_out <= 32'h8000_0000;
            else angle_out <= asum[31:0];
            gain_out <= gain_ff;
            acc_ff   <= hiprod_ff +
                        64'((33'(omk) * 33'(pp2_ff[15:0])) >> skaf_pkg::GAIN_BITS);
         end
         default: ;
      endcase
   end

   assign status.unit_busy = sqrt_busy | div_busy;
   assign status.den_zero  = (den_ff == 64'd0);

`ifndef ASSERT_OFF
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(sqrt_busy && div_busy)) else $error("root and divider busy together");
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == skaf_pkg::OP_ANGLE |-> gain_ff <= skaf_pkg::GAIN_ONE)
      else $error("gain above one");
   a_cov_range: assert property (@(posedge clock) disable iff (reset)
      !cov_ff[31]) else $error("covariance above limit");
`endif

endmodule

// ===== rtl/skaf_ctrl.sv =====
module skaf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output skaf_pkg::dp_cmd_type    cmd,
   input  skaf_pkg::dp_status_type status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRIOR = 4'd1;
   localparam logic [3:0] S_SQ1   = 4'd2;
   localparam logic [3:0] S_SQ2   = 4'd3;
   localparam logic [3:0] S_RPP   = 4'd4;
   localparam logic [3:0] S_WPP   = 4'd5;
   localparam logic [3:0] S_R2    = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_WDIV  = 4'd8;
   localparam logic [3:0] S_WK    = 4'd9;
   localparam logic [3:0] S_ANG   = 4'd10;
   localparam logic [3:0] S_SCL   = 4'd11;
   localparam logic [3:0] S_RP    = 4'd12;
   localparam logic [3:0] S_WP    = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       started_ff, started_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   // The word is offered only once the covariance root has settled.
   assign rsp_valid = (state_ff == S_OUT) && !started_ff && !status.unit_busy;

   always_comb begin
      state_in   = state_ff;
      started_in = 1'b0;
      cmd.op     = skaf_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd.op = skaf_pkg::OP_LOAD; state_in = S_PRIOR;
         end
         S_PRIOR: begin cmd.op = skaf_pkg::OP_PRIOR; state_in = S_SQ1; end
         S_SQ1:   begin cmd.op = skaf_pkg::OP_SQ1; state_in = S_SQ2; end
         S_SQ2:   begin cmd.op = skaf_pkg::OP_SQ2; state_in = S_RPP; end
         S_RPP:   begin cmd.op = skaf_pkg::OP_SQRT_PP; state_in = S_WPP; started_in = 1'b1; end
         S_WPP: if (!started_ff && !status.unit_busy) begin
            cmd.op = skaf_pkg::OP_PP2; state_in = S_R2;
         end
         S_R2:    begin cmd.op = skaf_pkg::OP_R2; state_in = S_DIV; end
         S_DIV: begin
            if (status.den_zero) state_in = S_ANG;
            else begin
               cmd.op = skaf_pkg::OP_DIV; state_in = S_WDIV; started_in = 1'b1;
            end
         end
         S_WDIV: if (!started_ff && !status.unit_busy) begin
            cmd.op = skaf_pkg::OP_SQRT_K; state_in = S_WK; started_in = 1'b1;
         end
         S_WK: if (!started_ff && !status.unit_busy) state_in = S_ANG;
         S_ANG: begin
            // The gain is latched here on the way into the correction step.
            cmd.op = skaf_pkg::OP_CORR; state_in = S_SCL;
         end
         S_SCL: begin cmd.op = skaf_pkg::OP_ANGLE; state_in = S_RP; end
         S_RP: begin
            cmd.op = skaf_pkg::OP_SCALE; state_in = S_WP;
         end
         S_WP: begin
            cmd.op = skaf_pkg::OP_SQRT_P; state_in = S_OUT; started_in = 1'b1;
         end
         S_OUT: if (rsp_valid && !rsp_stall) begin
            cmd.op = skaf_pkg::OP_COMMIT; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("input taken while busy");
   a_load_leaves: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_PRIOR) else $error("word accepted without start");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped under stall");
`endif

endmodule

// ===== rtl/scalar_kalman_angle_filter.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_accel_angle, req_gyro_rate
// rsp      out        rsp_valid/rsp_stall   rsp_angle_estimate, rsp_filter_gain
// csr      in         csr_valid/csr_ready   csr_index, csr_data
// A result is offered once three bit-serial roots and one bit-serial ratio divider have
// run one after another, plus control steps. A zero denominator skips the divider
// and the gain root.
// Reset is synchronous and restores the register defaults and a zero state.
// The result is held until taken; the next word is accepted the cycle after it leaves.
module scalar_kalman_angle_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_accel_angle,
   input  logic [31:0] req_gyro_rate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_angle_estimate,
   output logic [16:0] rsp_filter_gain,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [27:0] csr_data
);

   skaf_pkg::dp_cmd_type    cmd;
   skaf_pkg::dp_status_type status;
   logic [16:0] period_ff;
   logic [24:0] qnoise_ff;
   logic [27:0] rnoise_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= skaf_pkg::PERIOD_RESET;
         qnoise_ff <= skaf_pkg::QNOISE_RESET;
         rnoise_ff <= skaf_pkg::RNOISE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            skaf_pkg::CSR_PERIOD: period_ff <= csr_data[16:0];
            skaf_pkg::CSR_QNOISE: qnoise_ff <= csr_data[24:0];
            skaf_pkg::CSR_RNOISE: rnoise_ff <= csr_data;
            default: ;
         endcase
      end
   end

   skaf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .status(status)
   );

   skaf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .accel_angle(req_accel_angle), .gyro_rate(req_gyro_rate),
      .period(period_ff), .qnoise(qnoise_ff), .rnoise(rnoise_ff),
      .angle_out(rsp_angle_estimate), .gain_out(rsp_filter_gain)
   );

endmodule
